@@ sv/beacon_session_controller_assert.svh @@
// ----------------------------------------------------------------------------
// beacon session controller assertion macros
// concurrent checks clocked on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BEACON_SESSION_CONTROLLER_ASSERT_SVH
`define BEACON_SESSION_CONTROLLER_ASSERT_SVH

// property must hold at every edge out of reset
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen out of reset
`define BSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// types, codes and helpers shared by the beacon session controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  localparam int BSC_TIME_BITS = 32;
  localparam int BSC_ID_BITS   = 32;
  localparam int CFG_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;

  // result queue: two slots per item plus room for the beat in flight
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_BITS  = 88;
  localparam int OUT_TDATA_BITS = 40;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACK_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEACON_INT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOS_INT       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REUNITED_HOLD = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALERT_REPEAT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOS_PRESS     = 3'd5;

  localparam logic [CFG_BITS-1:0] RST_ACK_TIMEOUT   = 32'd30000;
  localparam logic [CFG_BITS-1:0] RST_BEACON_INT    = 32'd2000;
  localparam logic [CFG_BITS-1:0] RST_SOS_INT       = 32'd1000;
  localparam logic [CFG_BITS-1:0] RST_REUNITED_HOLD = 32'd5000;
  localparam logic [CFG_BITS-1:0] RST_ALERT_REPEAT  = 32'd3000;
  localparam logic [CFG_BITS-1:0] RST_SOS_PRESS     = 32'd2000;

  // session states, reported codes
  localparam logic [2:0] ST_ALERTING = 3'd0;
  localparam logic [2:0] ST_BEACON   = 3'd1;
  localparam logic [2:0] ST_SOS      = 3'd2;
  localparam logic [2:0] ST_REUNITED = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // message types
  localparam logic [2:0] MT_ACK        = 3'd0;
  localparam logic [2:0] MT_BEACON     = 3'd1;
  localparam logic [2:0] MT_REUNITE    = 3'd2;
  localparam logic [2:0] MT_SOS_ALERT  = 3'd3;
  localparam logic [2:0] MT_SOS_CANCEL = 3'd4;

  localparam logic [1:0] BEEP_NONE   = 2'd0;
  localparam logic [1:0] BEEP_DOUBLE = 2'd1;
  localparam logic [1:0] BEEP_SHORT  = 2'd2;
  localparam logic [1:0] BEEP_ERROR  = 2'd3;

  localparam logic [1:0] VIBE_NONE  = 2'd0;
  localparam logic [1:0] VIBE_SHORT = 2'd1;
  localparam logic [1:0] VIBE_LONG  = 2'd2;

  localparam logic [1:0] WIFI_NONE        = 2'd0;
  localparam logic [1:0] WIFI_HOTSPOT_ON  = 2'd1;
  localparam logic [1:0] WIFI_HOTSPOT_OFF = 2'd2;

  typedef enum logic [4:0] {
    M_ALERTING = 5'b00001,
    M_BEACON   = 5'b00010,
    M_SOS      = 5'b00100,
    M_REUNITED = 5'b01000,
    M_DONE     = 5'b10000
  } mode_e;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic              pkt_valid;
    logic [31:0]       pkt_sender;
    logic [2:0]        pkt_type;
    logic signed [8:0] pkt_strength;
    logic signed [7:0] pkt_peer_report;
    logic              select_pressed;
    logic              up_held;
  } item_t;

  typedef struct packed {
    logic       send_valid;
    logic [2:0] send_type;
    logic [1:0] beep;
    logic [1:0] vibe;
    logic [1:0] wifi;
  } act_t;

  typedef struct packed {
    logic [2:0]        session_state;
    logic              send_valid;
    logic [2:0]        send_type;
    logic signed [7:0] strength_report;
    logic [1:0]        beep_cmd;
    logic [1:0]        vibe_cmd;
    logic [1:0]        wifi_cmd;
    logic signed [8:0] local_strength;
    logic signed [7:0] remote_strength;
    logic              last_of_run;
  } res_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    case (m)
      M_ALERTING: c = ST_ALERTING;
      M_BEACON:   c = ST_BEACON;
      M_SOS:      c = ST_SOS;
      M_REUNITED: c = ST_REUNITED;
      default:    c = ST_DONE;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] sat8(logic signed [8:0] v);
    logic signed [7:0] r;
    if (v < -9'sd128) begin
      r = -8'sd128;
    end else if (v > 9'sd127) begin
      r = 8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/bsc_core.sv @@
// ----------------------------------------------------------------------------
// bsc_core
// session state, timing registers and the per-item step logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_core import bsc_pkg::*; #(
  parameter int TIME_BITS = BSC_TIME_BITS,
  parameter int ID_BITS   = BSC_ID_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]     cfg_data_i,
  input  wire logic                    step_i,
  input  wire item_t                   item_i,
  output res_t                         res_a_o,
  output res_t                         res_b_o,
  output logic                         two_o
);

  // compare width covers both the time counter and the 32-bit limits
  localparam int CW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic [CFG_BITS-1:0] ack_timeout_q, beacon_int_q, sos_int_q;
  logic [CFG_BITS-1:0] reunited_hold_q, alert_repeat_q, sos_press_q;

  mode_e                mode_q, mode_d;
  logic [ID_BITS-1:0]   peer_ident_q, peer_ident_d;
  logic [TIME_BITS-1:0] phase_start_q, phase_start_d;
  logic [TIME_BITS-1:0] last_send_q, last_send_d;
  logic [TIME_BITS-1:0] last_alert_q, last_alert_d;
  logic [TIME_BITS-1:0] last_sos_q, last_sos_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic                 pressing_q, pressing_d;
  logic signed [8:0]    peer_str_q, peer_str_d;
  logic signed [7:0]    peer_rep_q, peer_rep_d;

  logic [CW-1:0]        now_w;
  logic [TIME_BITS-1:0] now_t;
  logic                 got;
  act_t                 act_a, act_b;

  // wrapping elapsed time, compared against a register value
  function automatic logic el_ge(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] then,
                                 logic [CFG_BITS-1:0] lim);
    logic [TIME_BITS-1:0] el;
    el = now - then;
    return CW'(el) >= CW'(lim);
  endfunction

  // same, strictly past the limit
  function automatic logic el_gt(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] then,
                                 logic [CFG_BITS-1:0] lim);
    logic [TIME_BITS-1:0] el;
    el = now - then;
    return CW'(el) > CW'(lim);
  endfunction

  assign now_w = CW'(item_i.now_ms);
  assign now_t = now_w[TIME_BITS-1:0];
  assign got   = item_i.pkt_valid && (item_i.pkt_sender[ID_BITS-1:0] == peer_ident_q);

  always_comb begin
    logic reunite;
    reunite       = 1'b0;
    mode_d        = mode_q;
    peer_ident_d  = peer_ident_q;
    phase_start_d = phase_start_q;
    last_send_d   = last_send_q;
    last_alert_d  = last_alert_q;
    last_sos_d    = last_sos_q;
    press_start_d = press_start_q;
    pressing_d    = pressing_q;
    peer_str_d    = peer_str_q;
    peer_rep_d    = peer_rep_q;
    act_a         = '0;
    act_b         = '0;
    two_o         = 1'b0;

    if (item_i.kind) begin
      peer_ident_d  = item_i.pkt_sender[ID_BITS-1:0];
      peer_str_d    = item_i.pkt_strength;
      peer_rep_d    = item_i.pkt_peer_report;
      mode_d        = M_ALERTING;
      phase_start_d = now_t;
      last_alert_d  = '0;
      last_send_d   = now_t;
      pressing_d    = 1'b0;
      act_a.beep    = BEEP_ERROR;
    end else begin
      case (mode_q)
        M_ALERTING: begin
          if (el_ge(now_t, last_alert_q, alert_repeat_q)) begin
            last_alert_d = now_t;
            act_a.beep   = BEEP_DOUBLE;
            act_a.vibe   = VIBE_SHORT;
          end
          if (item_i.select_pressed) begin
            act_a.send_valid = 1'b1;
            act_a.send_type  = MT_ACK;
            act_a.wifi       = WIFI_HOTSPOT_ON;
            last_send_d      = now_t;
            mode_d           = M_BEACON;
          end else if (el_gt(now_t, phase_start_q, ack_timeout_q)) begin
            act_a.wifi = WIFI_HOTSPOT_OFF;
            mode_d     = M_DONE;
          end
        end
        M_BEACON: begin
          if (got) begin
            peer_str_d = item_i.pkt_strength;
            peer_rep_d = item_i.pkt_peer_report;
            if (item_i.pkt_type == MT_REUNITE) begin
              reunite       = 1'b1;
              act_a.wifi    = WIFI_HOTSPOT_OFF;
              act_a.beep    = BEEP_DOUBLE;
              act_a.vibe    = VIBE_LONG;
              mode_d        = M_REUNITED;
              phase_start_d = now_t;
            end
          end
          if (!reunite) begin
            if (el_ge(now_t, last_send_q, beacon_int_q)) begin
              act_a.send_valid = 1'b1;
              act_a.send_type  = MT_BEACON;
              last_send_d      = now_t;
            end
            if (item_i.select_pressed) begin
              // a beacon already took the first beat, confirm goes second
              if (act_a.send_valid) begin
                two_o            = 1'b1;
                act_b.send_valid = 1'b1;
                act_b.send_type  = MT_REUNITE;
                act_b.wifi       = WIFI_HOTSPOT_OFF;
              end else begin
                act_a.send_valid = 1'b1;
                act_a.send_type  = MT_REUNITE;
                act_a.wifi       = WIFI_HOTSPOT_OFF;
              end
              mode_d = M_DONE;
            end else if (item_i.up_held) begin
              if (!pressing_q) begin
                pressing_d    = 1'b1;
                press_start_d = now_t;
              end else if (el_ge(now_t, press_start_q, sos_press_q)) begin
                pressing_d = 1'b0;
                mode_d     = M_SOS;
                last_sos_d = '0;
                act_a.beep = BEEP_ERROR;
              end
            end else begin
              pressing_d = 1'b0;
            end
          end
        end
        M_SOS: begin
          if (el_ge(now_t, last_sos_q, sos_int_q)) begin
            last_sos_d       = now_t;
            act_a.send_valid = 1'b1;
            act_a.send_type  = MT_SOS_ALERT;
            act_a.beep       = BEEP_SHORT;
          end
          if (got) begin
            peer_str_d = item_i.pkt_strength;
            peer_rep_d = item_i.pkt_peer_report;
          end
          if (item_i.select_pressed) begin
            if (act_a.send_valid) begin
              two_o            = 1'b1;
              act_b.send_valid = 1'b1;
              act_b.send_type  = MT_SOS_CANCEL;
            end else begin
              act_a.send_valid = 1'b1;
              act_a.send_type  = MT_SOS_CANCEL;
            end
            mode_d = M_BEACON;
          end
        end
        M_REUNITED: begin
          if (el_gt(now_t, phase_start_q, reunited_hold_q)) begin
            act_a.wifi = WIFI_HOTSPOT_OFF;
            mode_d     = M_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_a_o.session_state   = mode_code(mode_d);
    res_a_o.send_valid      = act_a.send_valid;
    res_a_o.send_type       = act_a.send_valid ? act_a.send_type : MT_ACK;
    res_a_o.strength_report = sat8(peer_str_d);
    res_a_o.beep_cmd        = act_a.beep;
    res_a_o.vibe_cmd        = act_a.vibe;
    res_a_o.wifi_cmd        = act_a.wifi;
    res_a_o.local_strength  = peer_str_d;
    res_a_o.remote_strength = peer_rep_d;
    res_a_o.last_of_run     = !two_o;

    res_b_o                 = res_a_o;
    res_b_o.send_valid      = act_b.send_valid;
    res_b_o.send_type       = act_b.send_valid ? act_b.send_type : MT_ACK;
    res_b_o.beep_cmd        = act_b.beep;
    res_b_o.vibe_cmd        = act_b.vibe;
    res_b_o.wifi_cmd        = act_b.wifi;
    res_b_o.last_of_run     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q   <= RST_ACK_TIMEOUT;
      beacon_int_q    <= RST_BEACON_INT;
      sos_int_q       <= RST_SOS_INT;
      reunited_hold_q <= RST_REUNITED_HOLD;
      alert_repeat_q  <= RST_ALERT_REPEAT;
      sos_press_q     <= RST_SOS_PRESS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_TIMEOUT:   ack_timeout_q   <= cfg_data_i;
        CFG_BEACON_INT:    beacon_int_q    <= cfg_data_i;
        CFG_SOS_INT:       sos_int_q       <= cfg_data_i;
        CFG_REUNITED_HOLD: reunited_hold_q <= cfg_data_i;
        CFG_ALERT_REPEAT:  alert_repeat_q  <= cfg_data_i;
        CFG_SOS_PRESS:     sos_press_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= M_DONE;
      peer_ident_q  <= '0;
      phase_start_q <= '0;
      last_send_q   <= '0;
      last_alert_q  <= '0;
      last_sos_q    <= '0;
      press_start_q <= '0;
      pressing_q    <= 1'b0;
      peer_str_q    <= '0;
      peer_rep_q    <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      peer_ident_q  <= peer_ident_d;
      phase_start_q <= phase_start_d;
      last_send_q   <= last_send_d;
      last_alert_q  <= last_alert_d;
      last_sos_q    <= last_sos_d;
      press_start_q <= press_start_d;
      pressing_q    <= pressing_d;
      peer_str_q    <= peer_str_d;
      peer_rep_q    <= peer_rep_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/bsc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bsc_out_fifo
// small result queue, takes up to two beats a cycle and gives one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_out_fifo import bsc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_a_i,
  input  wire logic                     push_b_i,
  input  wire res_t                     data_a_i,
  input  wire res_t                     data_b_i,
  input  wire logic                     pop_i,
  output res_t                          data_o,
  output logic                          valid_o,
  output logic [FIFO_CNT_BITS-1:0]      cnt_o
);

  res_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_b;
  logic [FIFO_CNT_BITS-1:0] cnt_q, cnt_d;

  assign wr_ptr_b = wr_ptr_q + FIFO_PTR_BITS'(1);
  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_BITS'(push_a_i) + FIFO_PTR_BITS'(push_b_i);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_BITS'(pop_i);
  assign cnt_d    = cnt_q + FIFO_CNT_BITS'(push_a_i) + FIFO_CNT_BITS'(push_b_i)
                  - FIFO_CNT_BITS'(pop_i);

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign cnt_o   = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_ptr_b] <= data_b_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/beacon_session_controller.sv @@
// ----------------------------------------------------------------------------
// beacon_session_controller
// target-side radio search session: alerting, beacon, sos, reunited, done
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+-------------------------------
//   s_axis    | in  | tvalid / tready        | tdata item fields, tuser kind
//   m_axis    | out | tvalid / tready        | tdata result fields, tlast
//   cfg       | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// an accepted beat is held in the input register until the queue has room, then its step is
// evaluated and one or two result beats land in a 4-entry result queue
// one item per cycle sustained while the queue keeps two free slots
// the input register advances only while the queue has two free slots,
// so a stalled m_axis backs up into s_axis tready
// reset: state done, timing registers at their defaults, queue empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "beacon_session_controller_assert.svh"

module beacon_session_controller import bsc_pkg::*; #(
  parameter int TIME_BITS = BSC_TIME_BITS,
  parameter int ID_BITS   = BSC_ID_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // now_ms, pkt_valid, pkt_sender, pkt_type, pkt_strength, pkt_peer_report,
  // select_pressed, up_held
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // kind
  input  wire logic                      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // session_state, send_valid, send_type, strength_report, beep_cmd,
  // vibe_cmd, wifi_cmd, local_strength, remote_strength
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
  // last_of_run
  output logic                           m_axis_tlast,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]       cfg_data_i
);

  item_t                    in_item;
  item_t                    stg_item_q;
  logic                     stg_valid_q, stg_valid_d;
  logic                     adv;
  logic                     s_accept;
  res_t                     res_a, res_b, head;
  logic                     two;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt;

  assign in_item.kind            = s_axis_tuser;
  assign in_item.now_ms          = s_axis_tdata[31:0];
  assign in_item.pkt_valid       = s_axis_tdata[32];
  assign in_item.pkt_sender      = s_axis_tdata[64:33];
  assign in_item.pkt_type        = s_axis_tdata[67:65];
  assign in_item.pkt_strength    = s_axis_tdata[76:68];
  assign in_item.pkt_peer_report = s_axis_tdata[84:77];
  assign in_item.select_pressed  = s_axis_tdata[85];
  assign in_item.up_held         = s_axis_tdata[86];

  // room for a two-beat run, independent of the output side this cycle
  assign adv           = stg_valid_q &&
                         (fifo_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign s_axis_tready = !stg_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign stg_valid_d   = s_accept ? 1'b1 : (adv ? 1'b0 : stg_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      stg_item_q <= in_item;
    end
  end

  bsc_core #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (adv),
    .item_i     (stg_item_q),
    .res_a_o    (res_a),
    .res_b_o    (res_b),
    .two_o      (two)
  );

  bsc_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (adv),
    .push_b_i (adv && two),
    .data_a_i (res_a),
    .data_b_i (res_b),
    .pop_i    (m_axis_tvalid && m_axis_tready),
    .data_o   (head),
    .valid_o  (m_axis_tvalid),
    .cnt_o    (fifo_cnt)
  );

  assign m_axis_tdata = {2'b00, head.remote_strength, head.local_strength, head.wifi_cmd,
                         head.vibe_cmd, head.beep_cmd, head.strength_report,
                         head.send_type, head.send_valid, head.session_state};
  assign m_axis_tlast = head.last_of_run;

  `BSC_ASSERT(a_cnt_bound, fifo_cnt <= FIFO_CNT_BITS'(FIFO_DEPTH), "result queue overfilled")
  `BSC_ASSERT(a_run_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "second beat of a run missing")
  `BSC_ASSERT(a_two_kind, adv && two |-> (res_b.send_type == MT_REUNITE || res_b.send_type == MT_SOS_CANCEL), "bad second message")
  `BSC_ASSERT(a_first_send, adv && two |-> res_a.send_valid && !res_a.last_of_run, "two-beat run without a first send")
  `BSC_ASSERT_NEVER(a_stall_empty, !s_axis_tready && !stg_valid_q, "input stalled with empty register")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the beacon session controller: a directed walk through
// every session state and its corner cases, then randomized sessions under
// several timing register settings, all checked beat by beat against an
// in-bench model of the session logic, with random idling on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] MT_RESERVED = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                      s_axis_tuser  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i  = '0;
  logic [CFG_BITS-1:0]       cfg_data_i = '0;

  beacon_session_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // now_ms, pkt_valid, pkt_sender, pkt_type, pkt_strength, pkt_peer_report,
    // select_pressed, up_held
    .s_axis_tdata  (s_axis_tdata),
    // kind
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // session_state, send_valid, send_type, strength_report, beep_cmd,
    // vibe_cmd, wifi_cmd, local_strength, remote_strength
    .m_axis_tdata  (m_axis_tdata),
    // last_of_run
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // stimulus and expected beats
  item_t item_backlog[$];
  res_t  due_results[$];

  // session model state
  logic [31:0]       reg_val [0:5];
  logic [2:0]        mode;
  logic [31:0]       peer_id;
  logic [31:0]       phase_t;
  logic [31:0]       send_t;
  logic [31:0]       alert_t;
  logic [31:0]       sos_t;
  logic [31:0]       press_t;
  logic              pressing;
  logic signed [8:0] local_str;
  logic signed [7:0] remote_str;

  // run bookkeeping
  int n_items     = 0;
  int n_results   = 0;
  int n_sessions  = 0;
  int n_doubles   = 0;
  int n_settings  = 1;
  int n_errors    = 0;
  logic [31:0] gen_now = '0;

  // stream control
  item_t cur_item;
  bit    holding     = 1'b0;
  int    drv_gap     = 0;
  int    mon_gap     = 0;
  bit    drv_idle_en = 1'b0;
  bit    mon_idle_en = 1'b0;
  bit    calm        = 1'b0;
  res_t  seen;
  res_t  want;
  int    stuck       = 0;

  initial begin
    reg_val[CFG_ACK_TIMEOUT]   = RST_ACK_TIMEOUT;
    reg_val[CFG_BEACON_INT]    = RST_BEACON_INT;
    reg_val[CFG_SOS_INT]       = RST_SOS_INT;
    reg_val[CFG_REUNITED_HOLD] = RST_REUNITED_HOLD;
    reg_val[CFG_ALERT_REPEAT]  = RST_ALERT_REPEAT;
    reg_val[CFG_SOS_PRESS]     = RST_SOS_PRESS;
    mode       = ST_DONE;
    peer_id    = '0;
    phase_t    = '0;
    send_t     = '0;
    alert_t    = '0;
    sos_t      = '0;
    press_t    = '0;
    pressing   = 1'b0;
    local_str  = '0;
    remote_str = '0;
  end

  function automatic logic [31:0] since(logic [31:0] now, logic [31:0] then_t);
    return now - then_t;
  endfunction

  function automatic res_t make_result(act_t a, logic last);
    res_t r;
    r.session_state = mode;
    r.send_valid    = a.send_valid;
    r.send_type     = a.send_valid ? a.send_type : MT_ACK;
    if (local_str < -9'sd128) begin
      r.strength_report = -8'sd128;
    end else if (local_str > 9'sd127) begin
      r.strength_report = 8'sd127;
    end else begin
      r.strength_report = local_str[7:0];
    end
    r.beep_cmd        = a.beep;
    r.vibe_cmd        = a.vibe;
    r.wifi_cmd        = a.wifi;
    r.local_strength  = local_str;
    r.remote_strength = remote_str;
    r.last_of_run     = last;
    return r;
  endfunction

  // advance the session by one item and queue the beats it produces
  task automatic step_session(item_t it);
    act_t        a;
    act_t        b;
    logic [31:0] now;
    logic        got;
    logic        two;
    a   = '0;
    b   = '0;
    two = 1'b0;
    now = it.now_ms;
    got = it.pkt_valid && (it.pkt_sender == peer_id);
    if (it.kind) begin
      peer_id    = it.pkt_sender;
      local_str  = it.pkt_strength;
      remote_str = it.pkt_peer_report;
      mode       = ST_ALERTING;
      phase_t    = now;
      alert_t    = '0;
      send_t     = now;
      pressing   = 1'b0;
      a.beep     = BEEP_ERROR;
      n_sessions++;
    end else begin
      case (mode)
        ST_ALERTING: begin
          if (since(now, alert_t) >= reg_val[CFG_ALERT_REPEAT]) begin
            alert_t = now;
            a.beep  = BEEP_DOUBLE;
            a.vibe  = VIBE_SHORT;
          end
          if (it.select_pressed) begin
            a.send_valid = 1'b1;
            a.send_type  = MT_ACK;
            a.wifi       = WIFI_HOTSPOT_ON;
            send_t       = now;
            mode         = ST_BEACON;
          end else if (since(now, phase_t) > reg_val[CFG_ACK_TIMEOUT]) begin
            a.wifi = WIFI_HOTSPOT_OFF;
            mode   = ST_DONE;
          end
        end
        ST_BEACON: begin
          if (got) begin
            local_str  = it.pkt_strength;
            remote_str = it.pkt_peer_report;
          end
          if (got && it.pkt_type == MT_REUNITE) begin
            a.wifi  = WIFI_HOTSPOT_OFF;
            a.beep  = BEEP_DOUBLE;
            a.vibe  = VIBE_LONG;
            mode    = ST_REUNITED;
            phase_t = now;
          end else begin
            if (since(now, send_t) >= reg_val[CFG_BEACON_INT]) begin
              a.send_valid = 1'b1;
              a.send_type  = MT_BEACON;
              send_t       = now;
            end
            if (it.select_pressed) begin
              // a beacon already due goes out first, the confirm follows
              if (a.send_valid) begin
                two          = 1'b1;
                b.send_valid = 1'b1;
                b.send_type  = MT_REUNITE;
                b.wifi       = WIFI_HOTSPOT_OFF;
              end else begin
                a.send_valid = 1'b1;
                a.send_type  = MT_REUNITE;
                a.wifi       = WIFI_HOTSPOT_OFF;
              end
              mode = ST_DONE;
            end else if (it.up_held) begin
              if (!pressing) begin
                pressing = 1'b1;
                press_t  = now;
              end else if (since(now, press_t) >= reg_val[CFG_SOS_PRESS]) begin
                pressing = 1'b0;
                mode     = ST_SOS;
                sos_t    = '0;
                a.beep   = BEEP_ERROR;
              end
            end else begin
              pressing = 1'b0;
            end
          end
        end
        ST_SOS: begin
          if (since(now, sos_t) >= reg_val[CFG_SOS_INT]) begin
            sos_t        = now;
            a.send_valid = 1'b1;
            a.send_type  = MT_SOS_ALERT;
            a.beep       = BEEP_SHORT;
          end
          if (got) begin
            local_str  = it.pkt_strength;
            remote_str = it.pkt_peer_report;
          end
          if (it.select_pressed) begin
            if (a.send_valid) begin
              two          = 1'b1;
              b.send_valid = 1'b1;
              b.send_type  = MT_SOS_CANCEL;
            end else begin
              a.send_valid = 1'b1;
              a.send_type  = MT_SOS_CANCEL;
            end
            mode = ST_BEACON;
          end
        end
        ST_REUNITED: begin
          if (since(now, phase_t) > reg_val[CFG_REUNITED_HOLD]) begin
            a.wifi = WIFI_HOTSPOT_OFF;
            mode   = ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    if (two) begin
      due_results.push_back(make_result(a, 1'b0));
      due_results.push_back(make_result(b, 1'b1));
      n_doubles++;
    end else begin
      due_results.push_back(make_result(a, 1'b1));
    end
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_session(cur_item);
        holding = 1'b0;
        n_items++;
        if (drv_idle_en && !calm && $urandom_range(0, 7) == 0) begin
          drv_gap = $urandom_range(1, 19);
        end
      end
      if (!holding) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          holding  = 1'b1;
          s_axis_tdata <= {1'b0, cur_item.up_held, cur_item.select_pressed,
                           cur_item.pkt_peer_report, cur_item.pkt_strength,
                           cur_item.pkt_type, cur_item.pkt_sender,
                           cur_item.pkt_valid, cur_item.now_ms};
          s_axis_tuser <= cur_item.kind;
        end
      end
      s_axis_tvalid <= holding;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      n_errors++;
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        seen.session_state   = m_axis_tdata[2:0];
        seen.send_valid      = m_axis_tdata[3];
        seen.send_type       = m_axis_tdata[6:4];
        seen.strength_report = m_axis_tdata[14:7];
        seen.beep_cmd        = m_axis_tdata[16:15];
        seen.vibe_cmd        = m_axis_tdata[18:17];
        seen.wifi_cmd        = m_axis_tdata[20:19];
        seen.local_strength  = m_axis_tdata[29:21];
        seen.remote_strength = m_axis_tdata[37:30];
        seen.last_of_run     = m_axis_tlast;
        if (due_results.size() == 0) begin
          n_errors++;
          $error("result beat with nothing expected: tdata %0h", m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          check_field("session_state", 32'(want.session_state), 32'(seen.session_state));
          check_field("send_valid", 32'(want.send_valid), 32'(seen.send_valid));
          check_field("send_type", 32'(want.send_type), 32'(seen.send_type));
          check_field("strength_report", 32'(want.strength_report),
                      32'(seen.strength_report));
          check_field("beep_cmd", 32'(want.beep_cmd), 32'(seen.beep_cmd));
          check_field("vibe_cmd", 32'(want.vibe_cmd), 32'(seen.vibe_cmd));
          check_field("wifi_cmd", 32'(want.wifi_cmd), 32'(seen.wifi_cmd));
          check_field("local_strength", 32'(want.local_strength),
                      32'(seen.local_strength));
          check_field("remote_strength", 32'(want.remote_strength),
                      32'(seen.remote_strength));
          check_field("last_of_run", 32'(want.last_of_run), 32'(seen.last_of_run));
        end
      end
      if (mon_gap > 0) begin
        mon_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (mon_idle_en && !calm && $urandom_range(0, 9) == 0) begin
          mon_gap = $urandom_range(1, 19);
        end
      end
    end
  end

  // ends the run when neither stream moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck <= 0;
      end else if (stuck >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  task automatic push_item(bit kind, logic [31:0] now, bit pv, logic [31:0] sender,
                           logic [2:0] ptype, int str, int rep, bit sel, bit up);
    item_t it;
    it.kind            = kind;
    it.now_ms          = now;
    it.pkt_valid       = pv;
    it.pkt_sender      = sender;
    it.pkt_type        = ptype;
    it.pkt_strength    = 9'(str);
    it.pkt_peer_report = 8'(rep);
    it.select_pressed  = sel;
    it.up_held         = up;
    item_backlog.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= CFG_SOS_PRESS) begin
      reg_val[idx] = val;
    end
  endtask

  task automatic settle();
    while (item_backlog.size() != 0 || holding || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_dt(int unsigned scale);
    int unsigned pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) begin
      return 32'hFFFF_FFFF;  // one ms backwards, largest wrapped span
    end else if (pick == 1) begin
      return $urandom;
    end
    return $urandom_range(0, scale);
  endfunction

  function automatic logic [31:0] pick_id();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return 32'h0;
    end else if (pick == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  // sessions with plausible timing and packets, plus some pure noise
  task automatic gen_sessions(int budget, int unsigned scale);
    logic [31:0] peer;
    logic [2:0]  ptype;
    int          left;
    int unsigned pick;
    bit          hold;
    while (budget > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), $urandom,
                    3'($urandom_range(0, 7)), $urandom, $urandom,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          budget--;
        end
      end
      peer = pick_id();
      if ($urandom_range(0, 9) == 0) begin
        gen_now = $urandom;
      end
      push_item(1'b1, gen_now, 1'($urandom_range(0, 1)), peer, 3'($urandom_range(0, 7)),
                $urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      left = $urandom_range(4, 40);
      hold = 1'b0;
      budget -= left + 1;
      repeat (left) begin
        gen_now = gen_now + next_dt(scale);
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          ptype = MT_REUNITE;
        end else begin
          ptype = 3'($urandom_range(0, 7));
          if (ptype == MT_REUNITE) ptype = MT_BEACON;
        end
        if ($urandom_range(0, 5) == 0) hold = !hold;
        if ($urandom_range(0, 59) == 0) begin
          // restart in the middle of a session
          peer = pick_id();
          push_item(1'b1, gen_now, 1'($urandom_range(0, 1)), peer, ptype, $urandom, $urandom,
                    1'($urandom_range(0, 1)), hold);
        end else begin
          push_item(1'b0, gen_now, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 3) != 0) ? peer : $urandom, ptype,
                    $urandom, $urandom, $urandom_range(0, 9) == 0, hold);
        end
      end
    end
  endtask

  task automatic random_setting(output int unsigned scale);
    int unsigned base;
    logic [31:0] val;
    base = $urandom_range(1, 60);
    for (int r = CFG_ACK_TIMEOUT; r <= CFG_SOS_PRESS; r++) begin
      val = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3 * base);
      write_reg(CFG_IDX_BITS'(r), val);
    end
    scale = 2 * base;
    n_settings++;
  endtask

  initial begin
    int unsigned scale;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk at reset timing
    push_item(1'b0, 32'h0, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, MT_RESERVED, -1, -1, 1'b1, 1'b1);
    // start: strength above range saturates the report
    push_item(1'b1, 32'd5000, 1'b0, 32'hFFFF_FFFF, MT_ACK, 255, -128, 1'b0, 1'b0);
    push_item(1'b0, 32'd5000, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'd5001, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'd8001, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'd8002, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b1, 1'b0);
    push_item(1'b0, 32'd8100, 1'b1, 32'hFFFF_FFFF, MT_BEACON, -256, 127, 1'b0, 1'b0);
    push_item(1'b0, 32'd10002, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    // long up press into sos
    push_item(1'b0, 32'd10100, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b1);
    push_item(1'b0, 32'd12099, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b1);
    push_item(1'b0, 32'd12100, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b1);
    push_item(1'b0, 32'd12101, 1'b1, 32'hFFFF_FFFF, MT_SOS_ALERT, 10, 3, 1'b0, 1'b0);
    // alert due and cancel in one step: two beats
    push_item(1'b0, 32'd13101, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b1, 1'b0);
    push_item(1'b0, 32'd13200, 1'b1, 32'd1234, MT_REUNITE, 5, 5, 1'b0, 1'b0);
    push_item(1'b0, 32'd13300, 1'b1, 32'hFFFF_FFFF, MT_RESERVED, 100, -5, 1'b0, 1'b0);
    push_item(1'b0, 32'd13400, 1'b1, 32'hFFFF_FFFF, MT_SOS_CANCEL, -9, 9, 1'b0, 1'b0);
    push_item(1'b0, 32'd13500, 1'b1, 32'hFFFF_FFFF, MT_REUNITE, -20, -30, 1'b0, 1'b0);
    push_item(1'b0, 32'd18500, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'd18501, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    // wrapped timestamps, acknowledge timeout
    push_item(1'b1, 32'hFFFF_FF00, 1'b1, 32'h0, MT_ACK, -200, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'hFFFF_FF00 + 32'd30001, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b0, 1'b0);
    // beacon due and select in one step
    push_item(1'b1, 32'd100, 1'b0, 32'd42, MT_ACK, 0, 0, 1'b0, 1'b0);
    push_item(1'b0, 32'd100, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b1, 1'b0);
    push_item(1'b0, 32'd2100, 1'b0, 32'h0, MT_ACK, 0, 0, 1'b1, 1'b0);
    settle();

    drv_idle_en = 1'b1;
    mon_idle_en = 1'b1;
    gen_sessions(300, 1500);
    settle();

    for (int r = CFG_ACK_TIMEOUT; r <= CFG_SOS_PRESS; r++) begin
      write_reg(CFG_IDX_BITS'(r), 32'h0);
    end
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    n_settings++;
    gen_sessions(200, 3);
    settle();

    for (int r = CFG_ACK_TIMEOUT; r <= CFG_SOS_PRESS; r++) begin
      write_reg(CFG_IDX_BITS'(r), 32'hFFFF_FFFF);
    end
    n_settings++;
    gen_sessions(200, 800);
    settle();

    repeat (4) begin
      random_setting(scale);
      drv_idle_en = $urandom_range(0, 3) != 0;
      mon_idle_en = $urandom_range(0, 3) != 0;
      gen_sessions(250, scale);
      settle();
    end

    // closing stretch at full rate
    calm = 1'b1;
    random_setting(scale);
    gen_sessions(300, scale);
    settle();
    repeat (8) @(posedge clk_i);

    n_errors += due_results.size();
    $display("ran %0d input beats over %0d sessions and %0d register settings",
             n_items, n_sessions, n_settings);
    $display("checked %0d result beats, %0d items gave two beats", n_results, n_doubles);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_core.sv
sv/bsc_out_fifo.sv
sv/beacon_session_controller.sv
verif/tb_top.sv
